>>> design/pspa_pkg.sv
// Shared types and constants for the paged slot pool allocator.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package pspa_pkg;

  localparam int NUM_PAGES = 16;
  localparam int NUM_SLOTS = 64;
  localparam int PAGE_W    = $clog2(NUM_PAGES);
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int ADDR_W    = PAGE_W + SLOT_W;
  localparam int KEY_W     = 32;
  localparam int DEF_W     = 16;
  localparam int FILL_W    = 7;
  localparam int SPR_W     = 5;
  localparam int CNT_W     = 32;

  localparam logic REQ_UPSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic CFG_SLOTS = 1'b0;
  localparam logic CFG_SPARE = 1'b1;

  typedef enum logic [2:0] {
    ACT_UPDATED  = 3'd0,
    ACT_ADD_PAGE = 3'd1,
    ACT_REUSED   = 3'd2,
    ACT_NEW_PAGE = 3'd3,
    ACT_REMOVED  = 3'd4,
    ACT_REJECTED = 3'd5
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_CMP, S_TAKE, S_MVRD, S_MVWR, S_FILL, S_SPARE, S_PLACE, S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic skip_page;
    logic next_slot;
    logic rd_last;
    logic move_wr;
    logic take_fill;
    logic spare_free;
    logic place;
    logic set_update;
    logic set_reject;
    logic set_remove;
  } cmd_t;

  typedef struct packed {
    logic is_remove;
    logic def_zero;
    logic scan_end;
    logic slot_live;
    logic key_hit;
    logic tag_match;
    logic not_last;
    logic last_zero;
  } status_t;

endpackage

>>> design/pspa_ctrl.sv
// Controller state machine for the paged slot pool allocator.
// Depends on pspa_pkg; drives the datapath through cmd_t, reads status_t.
`timescale 1ns / 1ps
module pspa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pspa_pkg::status_t st,
  output pspa_pkg::cmd_t    cmd
);
  import pspa_pkg::*;

  state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Sequence one request
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!st.is_remove && st.def_zero) begin
          cmd.set_reject = 1'b1;
          state_nxt      = S_OUT;
        end else if (st.scan_end) begin
          if (st.is_remove) begin
            cmd.set_reject = 1'b1;
            state_nxt      = S_OUT;
          end else begin
            state_nxt = S_PLACE;
          end
        end else if (!st.slot_live) begin
          cmd.skip_page = 1'b1;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (st.key_hit) begin
          if (!st.is_remove && st.tag_match) begin
            cmd.set_update = 1'b1;
            state_nxt      = S_OUT;
          end else begin
            state_nxt = S_TAKE;
          end
        end else begin
          cmd.next_slot = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_TAKE: state_nxt = st.not_last ? S_MVRD : S_FILL;
      S_MVRD: begin
        cmd.rd_last = 1'b1;
        state_nxt   = S_MVWR;
      end
      S_MVWR: begin
        cmd.move_wr = 1'b1;
        state_nxt   = S_FILL;
      end
      S_FILL: begin
        cmd.take_fill = 1'b1;
        if (st.last_zero) begin
          state_nxt = S_SPARE;
        end else if (st.is_remove) begin
          cmd.set_remove = 1'b1;
          state_nxt      = S_OUT;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_SPARE: begin
        cmd.spare_free = 1'b1;
        if (st.is_remove) begin
          cmd.set_remove = 1'b1;
          state_nxt      = S_OUT;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> design/pspa_datapath.sv
// Datapath for the paged slot pool allocator: page tags, slot key memory,
// configuration, counters and result registers. Depends on pspa_pkg.
`timescale 1ns / 1ps
module pspa_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pspa_pkg::cmd_t              cmd,
  output pspa_pkg::status_t           st,
  input  logic                        cfg_valid,
  input  logic                        cfg_index,
  input  logic [6:0]                  cfg_data,
  input  logic                        in_req_type,
  input  logic [pspa_pkg::KEY_W-1:0]  in_key,
  input  logic [pspa_pkg::DEF_W-1:0]  in_definition_id,
  input  logic                        in_backend,
  output logic                        out_ok,
  output logic [2:0]                  out_action,
  output logic [3:0]                  out_page_index,
  output logic [5:0]                  out_slot_index,
  output logic                        out_moved,
  output logic [pspa_pkg::KEY_W-1:0]  out_moved_key,
  output logic                        out_page_retired,
  output logic                        out_page_freed,
  output logic [pspa_pkg::CNT_W-1:0]  out_alloc_count,
  output logic [pspa_pkg::CNT_W-1:0]  out_reuse_count
);
  import pspa_pkg::*;

  // Configuration
  logic [FILL_W-1:0] spp_r;
  logic [SPR_W-1:0]  msp_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spp_r <= FILL_W'(NUM_SLOTS);
      msp_r <= SPR_W'(2);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_SLOTS) spp_r <= cfg_data;
      else                        msp_r <= cfg_data[SPR_W-1:0];
    end
  end

  logic [FILL_W-1:0] lim;
  always_comb begin
    if (spp_r == '0)                     lim = FILL_W'(1);
    else if (spp_r > FILL_W'(NUM_SLOTS)) lim = FILL_W'(NUM_SLOTS);
    else                                 lim = spp_r;
  end

  // Latched request
  logic              req_r;
  logic [KEY_W-1:0]  key_r;
  logic [DEF_W-1:0]  def_in_r;
  logic              be_in_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= in_req_type;
      key_r    <= in_key;
      def_in_r <= in_definition_id;
      be_in_r  <= in_backend;
    end
  end

  // Page table
  logic [NUM_PAGES-1:0] used_r, spare_r, be_r;
  logic [DEF_W-1:0]     def_r  [NUM_PAGES];
  logic [FILL_W-1:0]    fill_r [NUM_PAGES];
  logic [CNT_W-1:0]     alloc_r, reuse_r;

  // Scan pointer
  logic [PAGE_W-1:0] pg_r;
  logic [SLOT_W-1:0] sl_r;
  logic              end_r;

  // Slot key memory
  logic [KEY_W-1:0]  mem [NUM_PAGES*NUM_SLOTS];
  logic [KEY_W-1:0]  rdata_r;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [KEY_W-1:0]  wr_data;
  logic              wr_en;

  logic [FILL_W-1:0] cur_fill, last;
  assign cur_fill = fill_r[pg_r];
  assign last     = cur_fill - FILL_W'(1);

  // Place target search, first match in priority order
  logic              t_found;
  logic [PAGE_W-1:0] t_pg;
  action_t           t_act;
  logic              f_act, f_spr, f_new;
  logic [PAGE_W-1:0] p_act, p_spr, p_new;
  always_comb begin
    f_act = 1'b0; f_spr = 1'b0; f_new = 1'b0;
    p_act = '0;   p_spr = '0;   p_new = '0;
    for (int i = NUM_PAGES - 1; i >= 0; i--) begin
      if (used_r[i] && !spare_r[i] && def_r[i] == def_in_r && be_r[i] == be_in_r &&
          fill_r[i] < lim) begin
        f_act = 1'b1; p_act = PAGE_W'(i);
      end
      if (used_r[i] && spare_r[i] && be_r[i] == be_in_r) begin
        f_spr = 1'b1; p_spr = PAGE_W'(i);
      end
      if (!used_r[i]) begin
        f_new = 1'b1; p_new = PAGE_W'(i);
      end
    end
    t_found = f_act | f_spr | f_new;
    if (f_act) begin
      t_pg = p_act; t_act = ACT_ADD_PAGE;
    end else if (f_spr) begin
      t_pg = p_spr; t_act = ACT_REUSED;
    end else begin
      t_pg = p_new; t_act = ACT_NEW_PAGE;
    end
  end

  logic [SLOT_W-1:0] t_sl;
  assign t_sl = f_act ? fill_r[t_pg][SLOT_W-1:0] : '0;

  // Count spares of the current page's backend
  logic [PAGE_W:0] spares;
  always_comb begin
    spares = '0;
    for (int i = 0; i < NUM_PAGES; i++)
      if (used_r[i] && spare_r[i] && be_r[i] == be_r[pg_r]) spares = spares + 1'b1;
  end

  // Memory ports
  assign rd_addr = cmd.rd_last ? {pg_r, last[SLOT_W-1:0]} : {pg_r, sl_r};
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {pg_r, sl_r};
    wr_data = rdata_r;
    if (cmd.move_wr) begin
      wr_en = 1'b1;
    end else if (cmd.place && t_found) begin
      wr_en   = 1'b1;
      wr_addr = {t_pg, t_sl};
      wr_data = key_r;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Advance the scan pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pg_r <= '0; sl_r <= '0; end_r <= 1'b0;
    end else if (cmd.load) begin
      pg_r <= '0; sl_r <= '0; end_r <= 1'b0;
    end else if (cmd.skip_page || (cmd.next_slot && sl_r == SLOT_W'(NUM_SLOTS - 1))) begin
      sl_r <= '0;
      if (pg_r == PAGE_W'(NUM_PAGES - 1)) end_r <= 1'b1;
      else                                pg_r  <= pg_r + 1'b1;
    end else if (cmd.next_slot) begin
      sl_r <= sl_r + 1'b1;
    end
  end

  // Update page tags and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0; spare_r <= '0; be_r <= '0;
      alloc_r <= '0; reuse_r <= '0;
      for (int i = 0; i < NUM_PAGES; i++) begin
        def_r[i]  <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      if (cmd.take_fill) begin
        fill_r[pg_r] <= last;
        if (last == '0) begin
          def_r[pg_r]   <= '0;
          spare_r[pg_r] <= 1'b1;
        end
      end
      if (cmd.spare_free && spares > msp_r) begin
        used_r[pg_r]  <= 1'b0;
        spare_r[pg_r] <= 1'b0;
        be_r[pg_r]    <= 1'b0;
      end
      if (cmd.place && t_found) begin
        used_r[t_pg]  <= 1'b1;
        spare_r[t_pg] <= 1'b0;
        def_r[t_pg]   <= def_in_r;
        be_r[t_pg]    <= be_in_r;
        fill_r[t_pg]  <= FILL_W'(t_sl) + FILL_W'(1);
        if (t_act == ACT_REUSED)   reuse_r <= reuse_r + 1'b1;
        if (t_act == ACT_NEW_PAGE) alloc_r <= alloc_r + 1'b1;
      end
    end
  end

  // Result registers
  logic              res_ok_r, res_mv_r, res_ret_r, res_fr_r;
  action_t           res_act_r;
  logic [PAGE_W-1:0] res_pg_r;
  logic [SLOT_W-1:0] res_sl_r;
  logic [KEY_W-1:0]  res_mk_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_ok_r <= 1'b0; res_act_r <= ACT_REJECTED; res_pg_r <= '0; res_sl_r <= '0;
      res_mv_r <= 1'b0; res_mk_r <= '0; res_ret_r <= 1'b0; res_fr_r <= 1'b0;
    end else begin
      if (cmd.move_wr && req_r == REQ_REMOVE) begin
        res_mv_r <= 1'b1;
        res_mk_r <= rdata_r;
      end
      if (cmd.take_fill && last == '0 && req_r == REQ_REMOVE) res_ret_r <= 1'b1;
      if (cmd.spare_free && spares > msp_r && req_r == REQ_REMOVE) res_fr_r <= 1'b1;
      if (cmd.set_reject || (cmd.place && !t_found)) begin
        res_ok_r <= 1'b0; res_act_r <= ACT_REJECTED; res_pg_r <= '0; res_sl_r <= '0;
      end else if (cmd.place) begin
        res_ok_r <= 1'b1; res_act_r <= t_act; res_pg_r <= t_pg; res_sl_r <= t_sl;
      end else if (cmd.set_update) begin
        res_ok_r <= 1'b1; res_act_r <= ACT_UPDATED; res_pg_r <= pg_r; res_sl_r <= sl_r;
      end else if (cmd.set_remove) begin
        res_ok_r <= 1'b1; res_act_r <= ACT_REMOVED; res_pg_r <= pg_r; res_sl_r <= sl_r;
      end
    end
  end

  // Status to the controller
  assign st.is_remove = (req_r == REQ_REMOVE);
  assign st.def_zero  = (def_in_r == '0);
  assign st.scan_end  = end_r;
  assign st.slot_live = used_r[pg_r] && !spare_r[pg_r] && ({1'b0, sl_r} < cur_fill);
  assign st.key_hit   = (rdata_r == key_r);
  assign st.tag_match = (def_r[pg_r] == def_in_r) && (be_r[pg_r] == be_in_r);
  assign st.not_last  = ({1'b0, sl_r} != last);
  assign st.last_zero = (last == '0);

  assign out_ok           = res_ok_r;
  assign out_action       = res_act_r;
  assign out_page_index   = res_pg_r;
  assign out_slot_index   = res_sl_r;
  assign out_moved        = res_mv_r;
  assign out_moved_key    = res_mk_r;
  assign out_page_retired = res_ret_r;
  assign out_page_freed   = res_fr_r;
  assign out_alloc_count  = alloc_r;
  assign out_reuse_count  = reuse_r;

endmodule

>>> design/paged_slot_pool_allocator.sv
// Paged slot pool allocator: 16 pages of up to 64 key slots with per-page
// tags. A request scans the active pages slot by slot in the key memory,
// reading and comparing each live slot in turn through the single-read key
// memory. Removal and placement then pass through the take, move read, move
// write, fill, spare and place states as needed. One request is in flight at
// a time; the result is held until taken. Configuration writes are always
// accepted. Depends on pspa_pkg.
`timescale 1ns / 1ps
module paged_slot_pool_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [6:0]                  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [pspa_pkg::KEY_W-1:0]  in_key,
  input  logic [pspa_pkg::DEF_W-1:0]  in_definition_id,
  input  logic                        in_backend,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_ok,
  output logic [2:0]                  out_action,
  output logic [3:0]                  out_page_index,
  output logic [5:0]                  out_slot_index,
  output logic                        out_moved,
  output logic [pspa_pkg::KEY_W-1:0]  out_moved_key,
  output logic                        out_page_retired,
  output logic                        out_page_freed,
  output logic [pspa_pkg::CNT_W-1:0]  out_alloc_count,
  output logic [pspa_pkg::CNT_W-1:0]  out_reuse_count
);
  import pspa_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  pspa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  pspa_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_req_type      (in_req_type),
    .in_key           (in_key),
    .in_definition_id (in_definition_id),
    .in_backend       (in_backend),
    .out_ok           (out_ok),
    .out_action       (out_action),
    .out_page_index   (out_page_index),
    .out_slot_index   (out_slot_index),
    .out_moved        (out_moved),
    .out_moved_key    (out_moved_key),
    .out_page_retired (out_page_retired),
    .out_page_freed   (out_page_freed),
    .out_alloc_count  (out_alloc_count),
    .out_reuse_count  (out_reuse_count)
  );

endmodule

>>> tb/tb_paged_slot_pool_allocator.sv
// Self-checking testbench for the paged slot pool allocator.
// Holds a scoreboard class that predicts each result; depends on pspa_pkg and the top level.
`timescale 1ns / 1ps
module tb_paged_slot_pool_allocator;
  import pspa_pkg::*;

  typedef struct {
    logic        ok;
    action_t     action;
    logic [3:0]  page;
    logic [5:0]  slot;
    logic        moved;
    logic [31:0] moved_key;
    logic        retired;
    logic        freed;
    logic [31:0] allocs;
    logic [31:0] reuses;
  } placement_t;

  // Mirror of the page table; predicts one placement per request
  class placement_scoreboard;
    bit          used [NUM_PAGES];
    bit          spare [NUM_PAGES];
    logic [15:0] defn [NUM_PAGES];
    bit          bknd [NUM_PAGES];
    int          fill [NUM_PAGES];
    logic [31:0] keys [NUM_PAGES*NUM_SLOTS];
    logic [31:0] allocs, reuses;
    int          slots_cfg, spare_cfg;
    placement_t  pending_q[$];
    int          errors, checked;
    int          act_seen [6];

    function new();
      for (int p = 0; p < NUM_PAGES; p++) begin
        used[p] = 0; spare[p] = 0; defn[p] = '0; bknd[p] = 0; fill[p] = 0;
      end
      allocs = '0; reuses = '0; slots_cfg = 64; spare_cfg = 2;
      errors = 0; checked = 0;
      foreach (act_seen[i]) act_seen[i] = 0;
    endfunction

    function void set_reg(logic idx, int val);
      if (idx == CFG_SLOTS) slots_cfg = val & 7'h7f;
      else spare_cfg = val & 5'h1f;
    endfunction

    function bit lookup(logic [31:0] k, output int pg, output int sl);
      pg = 0; sl = 0;
      for (int p = 0; p < NUM_PAGES; p++) begin
        if (!used[p] || spare[p]) continue;
        for (int s = 0; s < fill[p]; s++)
          if (keys[p*NUM_SLOTS+s] == k) begin
            pg = p; sl = s; return 1;
          end
      end
      return 0;
    endfunction

    // Pull key out of page p slot s; fill the hole with the last key
    function void evict(int p, int s, output bit mv, output logic [31:0] mk,
                        output bit ret, output bit fr);
      int last, cnt;
      last = fill[p] - 1;
      mv = 0; mk = '0; ret = 0; fr = 0;
      if (s != last) begin
        keys[p*NUM_SLOTS+s] = keys[p*NUM_SLOTS+last];
        mv = 1; mk = keys[p*NUM_SLOTS+s];
      end
      fill[p] = last;
      if (last == 0) begin
        defn[p] = '0; spare[p] = 1; ret = 1; cnt = 0;
        for (int q = 0; q < NUM_PAGES; q++)
          if (used[q] && spare[q] && bknd[q] == bknd[p]) cnt++;
        if (cnt > spare_cfg) begin
          used[p] = 0; spare[p] = 0; bknd[p] = 0; fr = 1;
        end
      end
    endfunction

    function void note_request(logic rq, logic [31:0] k, logic [15:0] d, logic b);
      placement_t r;
      int pg, sl, lim, tgt;
      bit mv, ret, fr, done;
      logic [31:0] mk;
      r = '{ok: 0, action: ACT_REJECTED, page: 0, slot: 0, moved: 0, moved_key: 0,
            retired: 0, freed: 0, allocs: 0, reuses: 0};
      if (rq == REQ_REMOVE) begin
        if (lookup(k, pg, sl)) begin
          evict(pg, sl, mv, mk, ret, fr);
          r.ok = 1; r.action = ACT_REMOVED; r.page = 4'(pg); r.slot = 6'(sl);
          r.moved = mv; r.moved_key = mk; r.retired = ret; r.freed = fr;
        end
      end else if (d != 0) begin
        done = 0;
        if (lookup(k, pg, sl)) begin
          if (defn[pg] == d && bknd[pg] == b) begin
            r.ok = 1; r.action = ACT_UPDATED; r.page = 4'(pg); r.slot = 6'(sl); done = 1;
          end else evict(pg, sl, mv, mk, ret, fr);
        end
        if (!done) begin
          lim = (slots_cfg == 0) ? 1 : (slots_cfg > NUM_SLOTS ? NUM_SLOTS : slots_cfg);
          tgt = -1;
          for (int p = 0; p < NUM_PAGES && tgt < 0; p++)
            if (used[p] && !spare[p] && defn[p] == d && bknd[p] == b && fill[p] < lim) begin
              tgt = p; r.action = ACT_ADD_PAGE;
            end
          for (int p = 0; p < NUM_PAGES && tgt < 0; p++)
            if (used[p] && spare[p] && bknd[p] == b) begin
              tgt = p; r.action = ACT_REUSED; reuses++;
            end
          for (int p = 0; p < NUM_PAGES && tgt < 0; p++)
            if (!used[p]) begin
              tgt = p; r.action = ACT_NEW_PAGE; allocs++; used[p] = 1;
            end
          if (tgt >= 0) begin
            if (r.action != ACT_ADD_PAGE) begin
              spare[tgt] = 0; defn[tgt] = d; bknd[tgt] = b; fill[tgt] = 0;
            end
            keys[tgt*NUM_SLOTS+fill[tgt]] = k;
            r.ok = 1; r.page = 4'(tgt); r.slot = 6'(fill[tgt]);
            fill[tgt]++;
          end else r.action = ACT_REJECTED;
        end
      end
      r.allocs = allocs; r.reuses = reuses;
      act_seen[r.action]++;
      pending_q.push_back(r);
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(placement_t a);
      placement_t e;
      if (pending_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      cmp("ok", e.ok, a.ok);
      cmp("action", e.action, a.action);
      cmp("page_index", e.page, a.page);
      cmp("slot_index", e.slot, a.slot);
      cmp("moved", e.moved, a.moved);
      cmp("moved_key", e.moved_key, a.moved_key);
      cmp("page_retired", e.retired, a.retired);
      cmp("page_freed", e.freed, a.freed);
      cmp("alloc_count", e.allocs, a.allocs);
      cmp("reuse_count", e.reuses, a.reuses);
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 5_000_000;

  logic        clk, rst_n;
  logic        cfg_valid, cfg_ready, cfg_index;
  logic [6:0]  cfg_data;
  logic        in_valid, in_ready, in_req_type, in_backend;
  logic [31:0] in_key;
  logic [15:0] in_definition_id;
  logic        out_valid, out_ready, out_ok, out_moved, out_page_retired, out_page_freed;
  logic [2:0]  out_action;
  logic [3:0]  out_page_index;
  logic [5:0]  out_slot_index;
  logic [31:0] out_moved_key, out_alloc_count, out_reuse_count;

  placement_scoreboard sb;
  bit          idle_en;
  int          cycles;
  int          stall_left;
  logic [31:0] key_pool [48];

  paged_slot_pool_allocator u_top (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Cycle count and hard stop
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("paged_slot_pool_allocator: mismatch");
      $finish;
    end
  end

  // Result side: stall in random bursts while idling is enabled
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(1, 6);
      out_ready <= 1'b0;
    end else out_ready <= 1'b1;
  end

  // Check each accepted result
  always @(posedge clk) begin
    placement_t a;
    if (rst_n && out_valid && out_ready) begin
      a.ok = out_ok; a.action = action_t'(out_action); a.page = out_page_index;
      a.slot = out_slot_index; a.moved = out_moved; a.moved_key = out_moved_key;
      a.retired = out_page_retired; a.freed = out_page_freed;
      a.allocs = out_alloc_count; a.reuses = out_reuse_count;
      sb.check_result(a);
    end
  end

  task automatic send_request(logic rq, logic [31:0] k, logic [15:0] d, logic b);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rq; in_key <= k; in_definition_id <= d; in_backend <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_request(rq, k, d, b);
  endtask

  // Hold off until every outstanding request has answered
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val[6:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic random_request();
    logic [31:0] k;
    logic [15:0] d;
    int sel;
    k = ($urandom_range(0, 15) == 0) ? $urandom : key_pool[$urandom_range(0, 47)];
    sel = $urandom_range(0, 19);
    if (sel == 0) d = '0;
    else if (sel < 3) d = 16'($urandom_range(1, 65535));
    else if (sel < 5) d = 16'hffff;
    else d = 16'($urandom_range(1, 3));
    send_request(($urandom_range(0, 9) < 4) ? REQ_REMOVE : REQ_UPSERT, k, d,
                 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int slots_set [6];
    int spare_set [6];
    slots_set = '{64, 1, 0, 127, 3, 5};
    spare_set = '{2, 0, 16, 31, 1, 4};
    sb = new();
    cycles = 0; idle_en = 1;
    rst_n = 1'b0; cfg_valid = 1'b0; cfg_index = CFG_SLOTS; cfg_data = '0;
    in_valid = 1'b0; in_req_type = REQ_UPSERT; in_key = '0; in_definition_id = '0;
    in_backend = 1'b0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = '0; key_pool[1] = '1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: two-slot pages, no spares kept on either backend
    write_reg(CFG_SLOTS, 2);
    write_reg(CFG_SPARE, 0);
    send_request(REQ_UPSERT, 32'h0, 16'd1, 1'b0);          // new page
    send_request(REQ_UPSERT, 32'hffffffff, 16'd1, 1'b0);   // same page
    send_request(REQ_UPSERT, 32'h0, 16'd1, 1'b0);          // update in place
    send_request(REQ_UPSERT, 32'h55, 16'd1, 1'b0);         // page full, new page
    send_request(REQ_UPSERT, 32'h0, 16'hffff, 1'b1);       // move to other def/backend
    send_request(REQ_UPSERT, 32'h0, 16'd0, 1'b0);          // zero definition
    send_request(REQ_REMOVE, 32'h12345678, 16'd0, 1'b0);   // unknown key
    send_request(REQ_UPSERT, 32'haa, 16'd1, 1'b0);
    send_request(REQ_REMOVE, 32'hffffffff, 16'd0, 1'b0);   // swap last key in
    send_request(REQ_REMOVE, 32'haa, 16'd0, 1'b0);         // page empties, freed
    send_request(REQ_REMOVE, 32'h0, 16'd0, 1'b1);          // retire and free on backend 1
    drain();
    write_reg(CFG_SPARE, 1);
    send_request(REQ_UPSERT, 32'h77, 16'd9, 1'b1);         // new page on backend 1, no spare left
    send_request(REQ_REMOVE, 32'h55, 16'd0, 1'b0);         // retire, kept
    send_request(REQ_UPSERT, 32'h88, 16'd4, 1'b0);         // reuse backend 0 spare
    send_request(REQ_REMOVE, 32'h77, 16'd0, 1'b1);
    send_request(REQ_REMOVE, 32'h88, 16'd0, 1'b0);
    drain();

    // Random phases across register settings, idling off in the last one
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_SLOTS, slots_set[ph]);
      write_reg(CFG_SPARE, spare_set[ph]);
      if (ph == 5) idle_en = 0;
      repeat (125) random_request();
      drain();
    end

    repeat (60) @(posedge clk);
    $display("Checked %0d results: %0d adds to new pages, %0d spare reuses, %0d removals,",
             sb.checked, sb.act_seen[ACT_NEW_PAGE], sb.act_seen[ACT_REUSED],
             sb.act_seen[ACT_REMOVED]);
    $display("%0d in-place updates and %0d rejections over six register settings.",
             sb.act_seen[ACT_UPDATED], sb.act_seen[ACT_REJECTED]);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("paged_slot_pool_allocator: match");
    end else begin
      $display("paged_slot_pool_allocator: mismatch");
    end
    $finish;
  end
endmodule

>>> sim.f
design/pspa_pkg.sv
design/pspa_ctrl.sv
design/pspa_datapath.sv
design/paged_slot_pool_allocator.sv
tb/tb_paged_slot_pool_allocator.sv
